>>> src/mcs_pkg.sv
// Package: field widths, register map and key codes of the mouse camera smoother.
`timescale 1ns / 1ps

package mcs_pkg;

  localparam int unsigned DATA_W   = 16;
  localparam int unsigned DZ_W     = 8;
  localparam int unsigned BTN_W    = 2;
  localparam int unsigned APB_W    = 32;
  localparam int unsigned PADDR_W  = 4;

  typedef logic [DATA_W-1:0]        word_t;
  typedef logic signed [DATA_W-1:0] sword_t;

  typedef enum logic [1:0] {
    REG_CENTER_X  = 2'd0,
    REG_CENTER_Y  = 2'd1,
    REG_DEAD_ZONE = 2'd2
  } reg_idx_t;

  localparam word_t          CENTER_X_RST  = 16'h0140;
  localparam word_t          CENTER_Y_RST  = 16'h0200;
  localparam logic [DZ_W-1:0] DEAD_ZONE_RST = 8'd5;

  localparam word_t  KEY_UP    = 16'h4800;
  localparam word_t  KEY_DOWN  = 16'h5000;
  localparam logic [7:0] KEY_SPACE = 8'h20;

  localparam sword_t DEPTH_GROW    = 16'sd10;
  localparam sword_t DEPTH_PULL    = 16'sd8;
  localparam sword_t DEPTH_FLOOR   = -16'sd8;
  localparam sword_t LATCH_DROP    = 16'sd64;
  localparam sword_t LATCH_FORCE   = -16'sd100;
  localparam sword_t KEY_NUDGE     = 16'sd8;

endpackage

>>> src/mcs_in_if.sv
// Interface: input item channel carrying one frame's mouse sample.
`timescale 1ns / 1ps

interface mcs_in_if;
  logic                           valid;
  logic                           ready;
  logic [mcs_pkg::DATA_W-1:0]     mouse_x;
  logic [mcs_pkg::DATA_W-1:0]     mouse_y;
  logic [mcs_pkg::BTN_W-1:0]      buttons;
  logic                           control_latch;
  logic [mcs_pkg::DATA_W-1:0]     key_code;

  modport source (output valid, mouse_x, mouse_y, buttons, control_latch, key_code,
                  input ready);
  modport sink   (input valid, mouse_x, mouse_y, buttons, control_latch, key_code,
                  output ready);
endinterface

>>> src/mcs_out_if.sv
// Interface: result item channel carrying camera pan, pitch and depth.
`timescale 1ns / 1ps

interface mcs_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [mcs_pkg::DATA_W-1:0]  pan;
  logic signed [mcs_pkg::DATA_W-1:0]  pan_secondary;
  logic signed [mcs_pkg::DATA_W-1:0]  pitch;
  logic signed [mcs_pkg::DATA_W-1:0]  cam_depth;
  logic                               space_flag;

  modport source (output valid, pan, pan_secondary, pitch, cam_depth, space_flag,
                  input ready);
  modport sink   (input valid, pan, pan_secondary, pitch, cam_depth, space_flag,
                  output ready);
endinterface

>>> src/mouse_camera_smoother_core.sv
// Top level: mouse camera smoother with APB register port.
`timescale 1ns / 1ps

// Takes one mouse item per clock while the output is not stalled and returns
// one result item per input item. An accepted item lands in an input register;
// once the result side can take it, all of the centering, dead zone, smoothing
// and depth arithmetic runs in one pass and writes both the filter state and
// the result register. Throughput is one item per cycle while the output is not
// stalled, as the five 16-bit state registers update together. The result register
// holds under back pressure while a new item may still sit in the input
// register. Registers: center_x at 0x0, center_y at 0x4, dead_zone at 0x8;
// write only while the block is idle.
module mouse_camera_smoother_core (
  input  logic                          clk,
  input  logic                          rst_n,
  mcs_in_if.sink                        in_chan,
  mcs_out_if.source                     out_chan,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mcs_pkg::PADDR_W-1:0]   paddr,
  input  logic [mcs_pkg::APB_W-1:0]     pwdata,
  output logic [mcs_pkg::APB_W-1:0]     prdata,
  output logic                          pready
);

  // configuration
  mcs_pkg::word_t             center_x_r;
  mcs_pkg::word_t             center_y_r;
  logic [mcs_pkg::DZ_W-1:0]   dead_zone_r;
  mcs_pkg::reg_idx_t          reg_sel;
  logic                       cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = mcs_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r  <= mcs_pkg::CENTER_X_RST;
      center_y_r  <= mcs_pkg::CENTER_Y_RST;
      dead_zone_r <= mcs_pkg::DEAD_ZONE_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        mcs_pkg::REG_CENTER_X:  center_x_r  <= pwdata[mcs_pkg::DATA_W-1:0];
        mcs_pkg::REG_CENTER_Y:  center_y_r  <= pwdata[mcs_pkg::DATA_W-1:0];
        mcs_pkg::REG_DEAD_ZONE: dead_zone_r <= pwdata[mcs_pkg::DZ_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      mcs_pkg::REG_CENTER_X:  prdata = {{(mcs_pkg::APB_W-mcs_pkg::DATA_W){1'b0}}, center_x_r};
      mcs_pkg::REG_CENTER_Y:  prdata = {{(mcs_pkg::APB_W-mcs_pkg::DATA_W){1'b0}}, center_y_r};
      mcs_pkg::REG_DEAD_ZONE: prdata = {{(mcs_pkg::APB_W-mcs_pkg::DZ_W){1'b0}}, dead_zone_r};
      default:                prdata = '0;
    endcase
  end

  // input register
  logic                         s1_valid_r;
  mcs_pkg::word_t               s1_mouse_x_r;
  mcs_pkg::word_t               s1_mouse_y_r;
  logic [mcs_pkg::BTN_W-1:0]    s1_buttons_r;
  logic                         s1_latch_r;
  mcs_pkg::word_t               s1_key_r;

  logic out_valid_r;
  logic s2_take;
  logic s1_take;

  assign s2_take        = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready  = !s1_valid_r || !out_valid_r || out_chan.ready;
  assign s1_take        = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      s1_mouse_x_r <= in_chan.mouse_x;
      s1_mouse_y_r <= in_chan.mouse_y;
      s1_buttons_r <= in_chan.buttons;
      s1_latch_r   <= in_chan.control_latch;
      s1_key_r     <= in_chan.key_code;
    end
  end

  // symmetric dead zone: inside [-dz, dz] collapses to zero
  function automatic mcs_pkg::sword_t dead_band(mcs_pkg::sword_t v,
                                                logic [mcs_pkg::DZ_W-1:0] dz);
    mcs_pkg::sword_t dz_s;
    mcs_pkg::sword_t lo;
    mcs_pkg::sword_t hi;
    dz_s = mcs_pkg::sword_t'({{(mcs_pkg::DATA_W-mcs_pkg::DZ_W){1'b0}}, dz});
    lo   = v - dz_s;
    hi   = v + dz_s;
    if (!lo[mcs_pkg::DATA_W-1]) begin
      dead_band = lo;
    end else if (!hi[mcs_pkg::DATA_W-1]) begin
      dead_band = '0;
    end else begin
      dead_band = hi;
    end
  endfunction

  // filter state
  mcs_pkg::sword_t filter_x_r, pan_r, pan2_r, pitch_r, depth_r;
  mcs_pkg::sword_t filter_x_nxt, pan_nxt, pan2_nxt, pitch_nxt, depth_nxt;
  logic            space_nxt;

  mcs_pkg::sword_t mx, my, h_half, h_dz, h_sm, h_scaled, h_sec;
  mcs_pkg::sword_t v_dz, v_dbl, v_sm;
  mcs_pkg::sword_t d_grow, d_decay, d_pull;

  always_comb begin
    // horizontal
    mx           = mcs_pkg::sword_t'(s1_mouse_x_r - center_x_r);
    h_half       = mx >>> 1;
    h_dz         = dead_band(h_half, dead_zone_r);
    h_sm         = (h_dz - filter_x_r) >>> 1;
    filter_x_nxt = h_sm;
    pan_nxt      = pan_r + h_sm;
    h_scaled     = h_sm <<< 3;
    h_sec        = (h_scaled - pan2_r) >>> 1;
    pan2_nxt     = pan2_r + h_sec;

    // vertical, inverted
    my           = mcs_pkg::sword_t'(s1_mouse_y_r - center_y_r);
    v_dz         = dead_band(-my, dead_zone_r);
    v_dbl        = v_dz <<< 1;
    v_sm         = (v_dbl - pitch_r) >>> 4;
    pitch_nxt    = pitch_r + v_sm;

    // depth step
    d_grow  = s1_buttons_r[0] ? depth_r + mcs_pkg::DEPTH_GROW : depth_r;
    d_decay = s1_buttons_r[1] ? d_grow - (d_grow >>> 3) - 16'sd1 : d_grow;
    if (d_decay <= mcs_pkg::DEPTH_FLOOR) begin
      d_pull = s1_latch_r ? d_decay + mcs_pkg::DEPTH_PULL - mcs_pkg::LATCH_DROP
                          : d_decay + mcs_pkg::DEPTH_PULL;
    end else if (s1_latch_r) begin
      d_pull = mcs_pkg::LATCH_FORCE;
    end else begin
      d_pull = d_decay;
    end

    space_nxt = 1'b0;
    if (s1_key_r == mcs_pkg::KEY_UP) begin
      depth_nxt = d_pull + mcs_pkg::KEY_NUDGE;
    end else if (s1_key_r == mcs_pkg::KEY_DOWN) begin
      depth_nxt = d_pull - mcs_pkg::KEY_NUDGE;
    end else begin
      depth_nxt = d_pull;
      space_nxt = (s1_key_r[7:0] == mcs_pkg::KEY_SPACE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_x_r <= '0;
      pan_r      <= '0;
      pan2_r     <= '0;
      pitch_r    <= '0;
      depth_r    <= '0;
    end else if (s2_take) begin
      filter_x_r <= filter_x_nxt;
      pan_r      <= pan_nxt;
      pan2_r     <= pan2_nxt;
      pitch_r    <= pitch_nxt;
      depth_r    <= depth_nxt;
    end
  end

  // result register
  logic space_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_chan.ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_take) begin
      space_r <= space_nxt;
    end
  end

  // the state registers hold exactly the last item's results
  assign out_chan.valid         = out_valid_r;
  assign out_chan.pan           = pan_r;
  assign out_chan.pan_secondary = pan2_r;
  assign out_chan.pitch         = pitch_r;
  assign out_chan.cam_depth     = depth_r;
  assign out_chan.space_flag    = space_r;

endmodule
